>>> hdl/prc_pkg.sv
// prc_pkg: widths, types, CORDIC arctangent table and rounding functions
// for the planar relative pose coefficient pipeline. No dependencies.
`timescale 1ns / 1ps

package prc_pkg;

    localparam int ANGLE_BITS        = 16;
    localparam int SINCOS_ITERATIONS = 16;

    localparam int POS_W   = 32;
    localparam int DIFF_W  = POS_W + 1;
    localparam int HEAD_W  = 16;
    localparam int PHASE_W = 32;
    localparam int TRIG_W  = 18;
    localparam int XW      = 34;
    localparam int ZW      = 34;
    localparam int GPROD_W = 2 * TRIG_W;
    localparam int GSUM_W  = GPROD_W + 1;
    localparam int OPROD_W = TRIG_W + DIFF_W;
    localparam int OSUM_W  = OPROD_W + 1;

    localparam int ATAN_ENTRIES  = 24;
    localparam int ATAN_IDX_W    = $clog2(ATAN_ENTRIES);
    localparam int CORDIC_STAGES =
        (SINCOS_ITERATIONS < ATAN_ENTRIES) ? SINCOS_ITERATIONS : ATAN_ENTRIES;

    localparam int UNIT_Q16     = 65536;
    localparam int CORDIC_START = 652032874;

    localparam logic [PHASE_W-1:0] PHASE_KEEP =
        ~((PHASE_W'(1) << (PHASE_W - ANGLE_BITS)) - PHASE_W'(1));

    localparam logic [31:0] ATAN_TABLE [ATAN_ENTRIES] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 flip;
    } cordic_lane_t;

    typedef struct packed {
        cordic_lane_t              child;
        cordic_lane_t              parent;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
    } rot_item_t;

    typedef struct packed {
        logic signed [TRIG_W-1:0]  cc;
        logic signed [TRIG_W-1:0]  sc;
        logic signed [TRIG_W-1:0]  cp;
        logic signed [TRIG_W-1:0]  sp;
        logic signed [DIFF_W-1:0]  dx;
        logic signed [DIFF_W-1:0]  dy;
    } trig_item_t;

    // Heading to folded CORDIC start vector (second/third quadrant turned by pi)
    function automatic cordic_lane_t lane_init(logic signed [HEAD_W-1:0] heading);
        cordic_lane_t       r;
        logic [PHASE_W-1:0] phase;
        logic               flip;
        phase  = {heading, (PHASE_W - HEAD_W)'(0)} & PHASE_KEEP;
        flip   = phase[PHASE_W-1] ^ phase[PHASE_W-2];
        phase  = phase ^ {flip, (PHASE_W - 1)'(0)};
        r.x    = XW'(CORDIC_START);
        r.y    = '0;
        r.z    = ZW'($signed(phase));
        r.flip = flip;
        return r;
    endfunction

    function automatic cordic_lane_t cordic_step(cordic_lane_t a,
                                                 logic [ATAN_IDX_W-1:0] idx);
        cordic_lane_t         r;
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] at;
        xs = a.x >>> idx;
        ys = a.y >>> idx;
        at = $signed(ZW'(ATAN_TABLE[idx]));
        if (!a.z[ZW-1]) begin
            r.x = a.x - ys;
            r.y = a.y + xs;
            r.z = a.z - at;
        end else begin
            r.x = a.x + ys;
            r.y = a.y - xs;
            r.z = a.z + at;
        end
        r.flip = a.flip;
        return r;
    endfunction

    function automatic rot_item_t rot_step(rot_item_t a, logic [ATAN_IDX_W-1:0] idx);
        rot_item_t r;
        r        = a;
        r.child  = cordic_step(a.child, idx);
        r.parent = cordic_step(a.parent, idx);
        return r;
    endfunction

    // Q4.30 to Q2.16, round half up, clamp to plus or minus one
    function automatic logic signed [TRIG_W-1:0] trig_round(logic signed [XW-1:0] x,
                                                            logic flip);
        logic signed [XW:0]    v;
        logic signed [XW:0]    t;
        logic signed [XW-14:0] q;
        logic signed [TRIG_W-1:0] r;
        v = flip ? -((XW+1)'(x)) : (XW+1)'(x);
        t = v + (XW+1)'(8192);
        q = $signed(t[XW:14]);
        if (q > UNIT_Q16)
            r = TRIG_W'(UNIT_Q16);
        else if (q < -UNIT_Q16)
            r = -TRIG_W'(UNIT_Q16);
        else
            r = q[TRIG_W-1:0];
        return r;
    endfunction

    function automatic logic signed [TRIG_W-1:0] gain_round(logic signed [GSUM_W-1:0] s);
        logic signed [GSUM_W:0]    t;
        logic signed [GSUM_W-16:0] q;
        logic signed [TRIG_W-1:0]  r;
        t = (GSUM_W+1)'(s) + (GSUM_W+1)'(32768);
        q = $signed(t[GSUM_W:16]);
        if (q > UNIT_Q16)
            r = TRIG_W'(UNIT_Q16);
        else if (q < -UNIT_Q16)
            r = -TRIG_W'(UNIT_Q16);
        else
            r = q[TRIG_W-1:0];
        return r;
    endfunction

    function automatic logic signed [POS_W-1:0] offset_round(logic signed [OSUM_W-1:0] s);
        logic signed [OSUM_W:0]    t;
        logic signed [OSUM_W-16:0] q;
        logic signed [OSUM_W-16:0] qmax;
        logic signed [OSUM_W-16:0] qmin;
        logic signed [POS_W-1:0]   r;
        qmax = (OSUM_W-15)'({1'b0, {(POS_W-1){1'b1}}});
        qmin = $signed((OSUM_W-15)'($signed({1'b1, (POS_W-1)'(0)})));
        t = (OSUM_W+1)'(s) + (OSUM_W+1)'(32768);
        q = $signed(t[OSUM_W:16]);
        if (q > qmax)
            r = qmax[POS_W-1:0];
        else if (q < qmin)
            r = qmin[POS_W-1:0];
        else
            r = q[POS_W-1:0];
        return r;
    endfunction

endpackage

>>> hdl/prc_cordic.sv
// prc_cordic: dual-lane rotation CORDIC, one iteration per register stage,
// followed by a rounding stage. Depends on prc_pkg.
`timescale 1ns / 1ps

module prc_cordic
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   up_valid,
    output logic                   up_ready,
    input  prc_pkg::rot_item_t     up_item,
    output logic                   dn_valid,
    input  logic                   dn_ready,
    output prc_pkg::trig_item_t    dn_item
);

    localparam int N = prc_pkg::CORDIC_STAGES;

    prc_pkg::rot_item_t  stg_reg [N];
    logic                vld_reg [N];
    logic [N:0]          rdy;
    logic                rnd_vld_reg;
    prc_pkg::trig_item_t rnd_reg;
    prc_pkg::trig_item_t rnd_next;

    assign rdy[N]   = !rnd_vld_reg || dn_ready;
    assign up_ready = rdy[0];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_iter
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
            if (k == 0) begin : g_first
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        vld_reg[k] <= 1'b0;
                    else if (rdy[k])
                        vld_reg[k] <= up_valid;
                end
                always_ff @(posedge clk)
                begin
                    if (rdy[k])
                        stg_reg[k] <= prc_pkg::rot_step(up_item,
                                                        prc_pkg::ATAN_IDX_W'(k));
                end
            end else begin : g_next
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        vld_reg[k] <= 1'b0;
                    else if (rdy[k])
                        vld_reg[k] <= vld_reg[k-1];
                end
                always_ff @(posedge clk)
                begin
                    if (rdy[k])
                        stg_reg[k] <= prc_pkg::rot_step(stg_reg[k-1],
                                                        prc_pkg::ATAN_IDX_W'(k));
                end
            end
        end
    endgenerate

    // undo the half-turn fold, round to Q2.16
    always_comb
    begin
        rnd_next.cc = prc_pkg::trig_round(stg_reg[N-1].child.x,  stg_reg[N-1].child.flip);
        rnd_next.sc = prc_pkg::trig_round(stg_reg[N-1].child.y,  stg_reg[N-1].child.flip);
        rnd_next.cp = prc_pkg::trig_round(stg_reg[N-1].parent.x, stg_reg[N-1].parent.flip);
        rnd_next.sp = prc_pkg::trig_round(stg_reg[N-1].parent.y, stg_reg[N-1].parent.flip);
        rnd_next.dx = stg_reg[N-1].dx;
        rnd_next.dy = stg_reg[N-1].dy;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rnd_vld_reg <= 1'b0;
        else if (rdy[N])
            rnd_vld_reg <= vld_reg[N-1];
    end

    always_ff @(posedge clk)
    begin
        if (rdy[N])
            rnd_reg <= rnd_next;
    end

    assign dn_valid = rnd_vld_reg;
    assign dn_item  = rnd_reg;

endmodule

>>> hdl/prc_combine.sv
// prc_combine: product stage and sum/round/saturate output stage forming the
// six affine coefficients. Depends on prc_pkg.
`timescale 1ns / 1ps

module prc_combine
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                up_valid,
    output logic                                up_ready,
    input  prc_pkg::trig_item_t                 up_item,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [prc_pkg::TRIG_W-1:0]   gain_xx,
    output logic signed [prc_pkg::TRIG_W-1:0]   gain_xy,
    output logic signed [prc_pkg::POS_W-1:0]    offset_x,
    output logic signed [prc_pkg::TRIG_W-1:0]   gain_yx,
    output logic signed [prc_pkg::TRIG_W-1:0]   gain_yy,
    output logic signed [prc_pkg::POS_W-1:0]    offset_y
);

    logic                                 mul_vld_reg;
    logic                                 mul_rdy;
    logic                                 out_rdy;
    logic signed [prc_pkg::GPROD_W-1:0]   p_cc_reg, p_ss_reg, p_cs_reg, p_sc_reg;
    logic signed [prc_pkg::OPROD_W-1:0]   q_cx_reg, q_sy_reg, q_sx_reg, q_cy_reg;
    logic signed [prc_pkg::GSUM_W-1:0]    g_same, g_xy, g_yx;
    logic signed [prc_pkg::OSUM_W-1:0]    o_x, o_y;
    logic                                 out_vld_reg;
    logic signed [prc_pkg::TRIG_W-1:0]    gxx_reg, gxy_reg, gyx_reg, gyy_reg;
    logic signed [prc_pkg::POS_W-1:0]     ox_reg, oy_reg;

    assign out_rdy  = !out_vld_reg || !out_stall;
    assign mul_rdy  = !mul_vld_reg || out_rdy;
    assign up_ready = mul_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_vld_reg <= 1'b0;
        else if (mul_rdy)
            mul_vld_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (mul_rdy)
        begin
            p_cc_reg <= up_item.cp * up_item.cc;
            p_ss_reg <= up_item.sp * up_item.sc;
            p_cs_reg <= up_item.cp * up_item.sc;
            p_sc_reg <= up_item.sp * up_item.cc;
            q_cx_reg <= up_item.cp * up_item.dx;
            q_sy_reg <= up_item.sp * up_item.dy;
            q_sx_reg <= up_item.sp * up_item.dx;
            q_cy_reg <= up_item.cp * up_item.dy;
        end
    end

    // xx and yy share one sum; xy and yx are opposite differences
    always_comb
    begin
        g_same = prc_pkg::GSUM_W'(p_cc_reg) + prc_pkg::GSUM_W'(p_ss_reg);
        g_xy   = prc_pkg::GSUM_W'(p_sc_reg) - prc_pkg::GSUM_W'(p_cs_reg);
        g_yx   = prc_pkg::GSUM_W'(p_cs_reg) - prc_pkg::GSUM_W'(p_sc_reg);
        o_x    = prc_pkg::OSUM_W'(q_cx_reg) + prc_pkg::OSUM_W'(q_sy_reg);
        o_y    = prc_pkg::OSUM_W'(q_cy_reg) - prc_pkg::OSUM_W'(q_sx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_rdy)
            out_vld_reg <= mul_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_rdy)
        begin
            gxx_reg <= prc_pkg::gain_round(g_same);
            gyy_reg <= prc_pkg::gain_round(g_same);
            gxy_reg <= prc_pkg::gain_round(g_xy);
            gyx_reg <= prc_pkg::gain_round(g_yx);
            ox_reg  <= prc_pkg::offset_round(o_x);
            oy_reg  <= prc_pkg::offset_round(o_y);
        end
    end

    assign out_valid = out_vld_reg;
    assign gain_xx   = gxx_reg;
    assign gain_xy   = gxy_reg;
    assign gain_yx   = gyx_reg;
    assign gain_yy   = gyy_reg;
    assign offset_x  = ox_reg;
    assign offset_y  = oy_reg;

endmodule

>>> hdl/planar_relative_pose_coefficients_core.sv
// planar_relative_pose_coefficients_core: child/parent planar poses in, affine
// coefficients out. Throughput one request per cycle while out_stall is low, set
// by the one-iteration-per-stage CORDIC pipeline. Reset (rst_n, asynchronous)
// clears the stage valid bits only; no clearing pass. Depends on prc_pkg,
// prc_cordic, prc_combine.
`timescale 1ns / 1ps

module planar_relative_pose_coefficients_core
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [prc_pkg::POS_W-1:0]    child_x,
    input  logic signed [prc_pkg::POS_W-1:0]    child_y,
    input  logic signed [prc_pkg::HEAD_W-1:0]   child_heading,
    input  logic signed [prc_pkg::POS_W-1:0]    parent_x,
    input  logic signed [prc_pkg::POS_W-1:0]    parent_y,
    input  logic signed [prc_pkg::HEAD_W-1:0]   parent_heading,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [prc_pkg::TRIG_W-1:0]   gain_xx,
    output logic signed [prc_pkg::TRIG_W-1:0]   gain_xy,
    output logic signed [prc_pkg::POS_W-1:0]    offset_x,
    output logic signed [prc_pkg::TRIG_W-1:0]   gain_yx,
    output logic signed [prc_pkg::TRIG_W-1:0]   gain_yy,
    output logic signed [prc_pkg::POS_W-1:0]    offset_y
);

    // Pipeline:
    //   entry stage  - heading to folded phase, exact 33-bit position deltas
    //   CORDIC       - one iteration per stage, both headings side by side
    //   round stage  - undo fold, Q4.30 -> Q2.16 with clamp
    //   product      - eight signed products
    //   output       - sums, rounding, saturation; doubles as output register
    // Each stage loads when it is empty or the stage after it moves, so
    // bubbles collapse and a stalled result does not block upstream fill.

    logic                 s0_vld_reg;
    prc_pkg::rot_item_t   s0_reg;
    prc_pkg::rot_item_t   s0_next;
    logic                 s0_rdy;

    logic                 cor_up_ready;
    logic                 cor_dn_valid;
    logic                 cmb_up_ready;
    prc_pkg::trig_item_t  cor_dn_item;

    always_comb
    begin
        s0_next.child  = prc_pkg::lane_init(child_heading);
        s0_next.parent = prc_pkg::lane_init(parent_heading);
        s0_next.dx     = prc_pkg::DIFF_W'(child_x) - prc_pkg::DIFF_W'(parent_x);
        s0_next.dy     = prc_pkg::DIFF_W'(child_y) - prc_pkg::DIFF_W'(parent_y);
    end

    assign s0_rdy   = !s0_vld_reg || cor_up_ready;
    assign in_stall = !s0_rdy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (s0_rdy)
            s0_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s0_rdy)
            s0_reg <= s0_next;
    end

    prc_cordic u_cordic
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (s0_vld_reg),
        .up_ready (cor_up_ready),
        .up_item  (s0_reg),
        .dn_valid (cor_dn_valid),
        .dn_ready (cmb_up_ready),
        .dn_item  (cor_dn_item)
    );

    prc_combine u_combine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (cor_dn_valid),
        .up_ready  (cmb_up_ready),
        .up_item   (cor_dn_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .gain_xx   (gain_xx),
        .gain_xy   (gain_xy),
        .offset_x  (offset_x),
        .gain_yx   (gain_yx),
        .gain_yy   (gain_yy),
        .offset_y  (offset_y)
    );

`ifndef ASSERT_OFF
    // an empty or draining output register must free the whole ready chain
    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || !out_stall) |-> !in_stall)
        else $error("input stalled while output side is free");

    // both diagonal gains come from the same sum
    a_diag_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gain_xx == gain_yy))
        else $error("diagonal gains differ");

    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (gain_xy <= prc_pkg::UNIT_Q16) && (gain_xy >= -prc_pkg::UNIT_Q16)
                      && (gain_yx <= prc_pkg::UNIT_Q16) && (gain_yx >= -prc_pkg::UNIT_Q16))
        else $error("off-diagonal gain out of unit range");
`endif

endmodule

>>> tb/sv/prc_pose_checker.sv
// prc_pose_checker: watches both channels of the pose coefficient core, predicts
// the six affine coefficients of every request and compares each result in order.
// Depends on prc_pkg for field widths and the angle resolution parameters.
`timescale 1ns / 1ps

module prc_pose_checker
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  logic signed [prc_pkg::POS_W-1:0]    child_x,
    input  logic signed [prc_pkg::POS_W-1:0]    child_y,
    input  logic signed [prc_pkg::HEAD_W-1:0]   child_heading,
    input  logic signed [prc_pkg::POS_W-1:0]    parent_x,
    input  logic signed [prc_pkg::POS_W-1:0]    parent_y,
    input  logic signed [prc_pkg::HEAD_W-1:0]   parent_heading,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  logic signed [prc_pkg::TRIG_W-1:0]   gain_xx,
    input  logic signed [prc_pkg::TRIG_W-1:0]   gain_xy,
    input  logic signed [prc_pkg::POS_W-1:0]    offset_x,
    input  logic signed [prc_pkg::TRIG_W-1:0]   gain_yx,
    input  logic signed [prc_pkg::TRIG_W-1:0]   gain_yy,
    input  logic signed [prc_pkg::POS_W-1:0]    offset_y,
    output int                                  fail_count,
    output int                                  outstanding,
    output int                                  requests_seen,
    output int                                  results_seen
);

    localparam longint CORDIC_GAIN_START = 652032874;   // K * 2^30
    localparam longint UNIT              = 65536;       // 1.0 in Q2.16
    localparam longint OFFSET_MAX        = 64'sd2147483647;
    localparam longint OFFSET_MIN        = -64'sd2147483648;
    localparam int     ATAN_STEPS        = 24;
    localparam int     PRINT_LIMIT       = 40;

    typedef struct packed {
        logic signed [prc_pkg::TRIG_W-1:0] gain_xx;
        logic signed [prc_pkg::TRIG_W-1:0] gain_xy;
        logic signed [prc_pkg::POS_W-1:0]  offset_x;
        logic signed [prc_pkg::TRIG_W-1:0] gain_yx;
        logic signed [prc_pkg::TRIG_W-1:0] gain_yy;
        logic signed [prc_pkg::POS_W-1:0]  offset_y;
    } pose_coeffs_t;

    pose_coeffs_t expected_coeffs[$];

    // arctan(2^-i) in units of 2^-32 turn
    function automatic longint atan_turns(int idx);
        case (idx)
            0:  return 536870912;
            1:  return 316933406;
            2:  return 167458907;
            3:  return 85004756;
            4:  return 42667331;
            5:  return 21354465;
            6:  return 10680862;
            7:  return 5340245;
            8:  return 2670163;
            9:  return 1335087;
            10: return 667544;
            11: return 333772;
            12: return 166886;
            13: return 83443;
            14: return 41722;
            15: return 20861;
            16: return 10430;
            17: return 5215;
            18: return 2608;
            19: return 1304;
            20: return 652;
            21: return 326;
            22: return 163;
            default: return 81;
        endcase
    endfunction

    function automatic longint clamp_range(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // heading -> cos, sin in Q2.16; quadrants two and three are folded by half a turn
    function automatic void heading_cos_sin(input logic signed [prc_pkg::HEAD_W-1:0] heading,
                                            output longint cos_q16, output longint sin_q16);
        logic [31:0] phase;
        logic [31:0] keep_mask;
        logic        folded;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        longint      ny;
        keep_mask = ~((32'd1 << (32 - prc_pkg::ANGLE_BITS)) - 32'd1);
        phase     = {heading, 16'h0000} & keep_mask;
        folded    = phase[31] ^ phase[30];
        if (folded)
            phase = phase + 32'h8000_0000;
        z = longint'($signed(phase));
        x = CORDIC_GAIN_START;
        y = 0;
        for (int i = 0; i < prc_pkg::SINCOS_ITERATIONS && i < ATAN_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - atan_turns(i);
            end else begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + atan_turns(i);
            end
            x = nx;
            y = ny;
        end
        if (folded) begin
            x = -x;
            y = -y;
        end
        cos_q16 = clamp_range((x + 8192) >>> 14, -UNIT, UNIT);
        sin_q16 = clamp_range((y + 8192) >>> 14, -UNIT, UNIT);
    endfunction

    function automatic logic signed [prc_pkg::TRIG_W-1:0] round_gain(longint sum);
        return prc_pkg::TRIG_W'(clamp_range((sum + 32768) >>> 16, -UNIT, UNIT));
    endfunction

    function automatic logic signed [prc_pkg::POS_W-1:0] round_offset(longint sum);
        return prc_pkg::POS_W'(clamp_range((sum + 32768) >>> 16, OFFSET_MIN, OFFSET_MAX));
    endfunction

    function automatic pose_coeffs_t predict_coeffs(
        logic signed [prc_pkg::POS_W-1:0]  cx,
        logic signed [prc_pkg::POS_W-1:0]  cy,
        logic signed [prc_pkg::HEAD_W-1:0] ch,
        logic signed [prc_pkg::POS_W-1:0]  px,
        logic signed [prc_pkg::POS_W-1:0]  py,
        logic signed [prc_pkg::HEAD_W-1:0] ph);
        pose_coeffs_t r;
        longint       cc;
        longint       sc;
        longint       cp;
        longint       sp;
        longint       dx;
        longint       dy;
        heading_cos_sin(ch, cc, sc);
        heading_cos_sin(ph, cp, sp);
        dx = longint'(cx) - longint'(px);   // exact on 33 bits
        dy = longint'(cy) - longint'(py);
        r.gain_xx  = round_gain(cp * cc + sp * sc);
        r.gain_xy  = round_gain(-cp * sc + sp * cc);
        r.offset_x = round_offset(cp * dx + sp * dy);
        r.gain_yx  = round_gain(-sp * cc + cp * sc);
        r.gain_yy  = round_gain(sp * sc + cp * cc);
        r.offset_y = round_offset(-sp * dx + cp * dy);
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (fail_count < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $time, msg);
        fail_count = fail_count + 1;
    endtask

    task automatic check_field(string name, int idx, longint got_v, longint want_v);
        if (got_v != want_v)
            report_mismatch($sformatf("result %0d %s = %0d, predicted %0d",
                                      idx, name, got_v, want_v));
    endtask

    initial
    begin
        fail_count    = 0;
        outstanding   = 0;
        requests_seen = 0;
        results_seen  = 0;
    end

    always @(posedge clk)
    begin : watch
        pose_coeffs_t got;
        pose_coeffs_t want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                got = {gain_xx, gain_xy, offset_x, gain_yx, gain_yy, offset_y};
                if ($isunknown(got))
                    report_mismatch($sformatf("result %0d carries unknown bits", results_seen));
                if (expected_coeffs.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no request outstanding",
                                              results_seen));
                end else begin
                    want = expected_coeffs.pop_front();
                    check_field("gain_xx", results_seen, got.gain_xx, want.gain_xx);
                    check_field("gain_xy", results_seen, got.gain_xy, want.gain_xy);
                    check_field("offset_x", results_seen, got.offset_x, want.offset_x);
                    check_field("gain_yx", results_seen, got.gain_yx, want.gain_yx);
                    check_field("gain_yy", results_seen, got.gain_yy, want.gain_yy);
                    check_field("offset_y", results_seen, got.offset_y, want.offset_y);
                end
                results_seen <= results_seen + 1;
            end
            if (in_valid && !in_stall) begin
                expected_coeffs.push_back(predict_coeffs(child_x, child_y, child_heading,
                                                         parent_x, parent_y, parent_heading));
                requests_seen <= requests_seen + 1;
            end
            outstanding <= expected_coeffs.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
// tb: drives pose-pair requests into planar_relative_pose_coefficients_core with
// random idling and back-pressure and gives the verdict.
// Depends on prc_pkg, the core and prc_pose_checker.
`timescale 1ns / 1ps

module tb;

    localparam int CLK_HALF        = 6;       // 12 ns period
    localparam int RANDOM_REQUESTS = 1230;
    localparam int HOLD_CYCLES     = 200;     // long output hold-off, well past pipeline depth
    localparam int HOLD_AFTER      = 300;     // requests accepted before the hold-off
    localparam int QUIET_FROM      = 600;     // stretch with no idling on either side
    localparam int QUIET_TO        = 800;
    localparam int DRAIN_AT        = 1000;    // random request index where the sender drains
    localparam int SETTLE_CYCLES   = 30;      // longer than the pipeline latency
    localparam int IDLE_PERCENT    = 11;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic signed [prc_pkg::POS_W-1:0]    child_x;
    logic signed [prc_pkg::POS_W-1:0]    child_y;
    logic signed [prc_pkg::HEAD_W-1:0]   child_heading;
    logic signed [prc_pkg::POS_W-1:0]    parent_x;
    logic signed [prc_pkg::POS_W-1:0]    parent_y;
    logic signed [prc_pkg::HEAD_W-1:0]   parent_heading;
    logic                                out_valid;
    logic                                out_stall;
    logic signed [prc_pkg::TRIG_W-1:0]   gain_xx;
    logic signed [prc_pkg::TRIG_W-1:0]   gain_xy;
    logic signed [prc_pkg::POS_W-1:0]    offset_x;
    logic signed [prc_pkg::TRIG_W-1:0]   gain_yx;
    logic signed [prc_pkg::TRIG_W-1:0]   gain_yy;
    logic signed [prc_pkg::POS_W-1:0]    offset_y;

    int fail_count;
    int outstanding;
    int requests_seen;
    int results_seen;

    planar_relative_pose_coefficients_core uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .child_x        (child_x),
        .child_y        (child_y),
        .child_heading  (child_heading),
        .parent_x       (parent_x),
        .parent_y       (parent_y),
        .parent_heading (parent_heading),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .gain_xx        (gain_xx),
        .gain_xy        (gain_xy),
        .offset_x       (offset_x),
        .gain_yx        (gain_yx),
        .gain_yy        (gain_yy),
        .offset_y       (offset_y)
    );

    // The checker sees exactly what the core sees and keeps its own prediction.
    prc_pose_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .child_x        (child_x),
        .child_y        (child_y),
        .child_heading  (child_heading),
        .parent_x       (parent_x),
        .parent_y       (parent_y),
        .parent_heading (parent_heading),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .gain_xx        (gain_xx),
        .gain_xy        (gain_xy),
        .offset_x       (offset_x),
        .gain_yx        (gain_yx),
        .gain_yy        (gain_yy),
        .offset_y       (offset_y),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .requests_seen  (requests_seen),
        .results_seen   (results_seen)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // Run-away guard: far beyond the slowest legal run.
    initial
    begin
        #(2 * CLK_HALF * 500_000);
        $display("RESULT: ERROR");
        $finish;
    end

    // Both sides stop idling while the request count sits in this window, so the
    // pipeline also runs flat out for a couple of hundred requests.
    function automatic bit quiet_stretch();
        return requests_seen >= QUIET_FROM && requests_seen < QUIET_TO;
    endfunction

    // Receiver: random stalls, plus one long hold-off counted here. The sender keeps
    // offering during it, so the pipeline fills and in_stall must rise.
    initial
    begin : receiver
        bit held;
        held      = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (!held && requests_seen >= HOLD_AFTER) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= !quiet_stretch() && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // One request: optional random gap, then hold the payload until accepted.
    // Returns at the accepting edge, so a back-to-back request re-drives valid
    // high only once in that step.
    task automatic send_pose(logic signed [prc_pkg::POS_W-1:0]  cx,
                             logic signed [prc_pkg::POS_W-1:0]  cy,
                             logic signed [prc_pkg::HEAD_W-1:0] ch,
                             logic signed [prc_pkg::POS_W-1:0]  px,
                             logic signed [prc_pkg::POS_W-1:0]  py,
                             logic signed [prc_pkg::HEAD_W-1:0] ph);
        if (!quiet_stretch() && $urandom_range(99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        child_x        <= cx;
        child_y        <= cy;
        child_heading  <= ch;
        parent_x       <= px;
        parent_y       <= py;
        parent_heading <= ph;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Positions: mostly full range, some small, some hugging the extremes so
    // the offsets saturate.
    function automatic logic [prc_pkg::POS_W-1:0] random_position();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            return $urandom;
        else if (pick < 85)
            return prc_pkg::POS_W'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
        else if (pick < 93)
            return 32'h7FFF_FFFF - $urandom_range(0, 1 << 16);
        else
            return 32'h8000_0000 + $urandom_range(0, 1 << 16);
    endfunction

    // Headings: mostly any angle, otherwise close to an eighth-turn boundary
    // where the quadrant fold and the CORDIC overshoot matter.
    function automatic logic [prc_pkg::HEAD_W-1:0] random_heading();
        logic [prc_pkg::HEAD_W-1:0] base;
        if ($urandom_range(99) < 60)
            return prc_pkg::HEAD_W'($urandom_range(0, 65535));
        base = prc_pkg::HEAD_W'($urandom_range(0, 7) * 8192);
        return base + prc_pkg::HEAD_W'($urandom_range(0, 6)) - prc_pkg::HEAD_W'(3);
    endfunction

    initial
    begin : stimulus
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        child_x        = '0;
        child_y        = '0;
        child_heading  = '0;
        parent_x       = '0;
        parent_y       = '0;
        parent_heading = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: origin, saturating offsets, full-scale and quadrant-edge headings
        send_pose(32'h0, 32'h0, 16'h0000, 32'h0, 32'h0, 16'h0000);
        send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000, 32'h8000_0000, 32'h8000_0000, 16'h0000);
        send_pose(32'h8000_0000, 32'h8000_0000, 16'h0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0000);
        send_pose(32'h0001_0000, 32'hFFFF_0000, 16'h8000, 32'h0, 32'h0, 16'h8000);
        send_pose(32'h0010_0000, 32'h0, 16'h7FFF, 32'h0, 32'h0010_0000, 16'h8000);
        send_pose(32'h0, 32'h0001_0000, 16'h4000, 32'h0001_0000, 32'h0, 16'hC000);
        send_pose(32'h1234_5678, 32'h0, 16'hC000, 32'h0, 32'h0, 16'h4000);
        send_pose(32'h0, 32'h0, 16'h2000, 32'h0, 32'h0, 16'h0000);
        send_pose(32'h0100_0000, 32'h0200_0000, 16'h0000, 32'h0, 32'h0, 16'h6000);
        send_pose(32'h0, 32'h0, 16'hE000, 32'h0300_0000, 32'h0, 16'hA000);
        send_pose(32'h0000_0001, 32'hFFFF_FFFF, 16'h0001, 32'h0, 32'h0, 16'hFFFF);
        send_pose(32'h0, 32'h0, 16'h3FFF, 32'h0, 32'h0, 16'h4001);
        send_pose(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'h2000);
        send_pose(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h1000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hF000);
        send_pose(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0001, 32'h0000_0001, 16'h0000);
        send_pose(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA);
        send_pose(32'h7FFF_FFFF, 32'h0, 16'h4000, 32'h8000_0000, 32'h0, 16'h4000);
        send_pose(32'h8000_0000, 32'h7FFF_FFFF, 16'h8001, 32'h7FFF_FFFF, 32'h8000_0000, 16'h7FFF);
        send_pose(32'h0, 32'h0, 16'h6000, 32'h0, 32'h0, 16'h9FFF);
        send_pose(32'h0, 32'h0, 16'hBFFF, 32'h0, 32'h0, 16'h4000);
        in_valid <= 1'b0;
        drain_results();

        // Random: the hold-off and the quiet stretch fall inside this part
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == DRAIN_AT) begin
                // sender pauses until the pipeline has emptied completely
                in_valid <= 1'b0;
                drain_results();
            end
            send_pose(random_position(), random_position(), random_heading(),
                      random_position(), random_position(), random_heading());
        end
        in_valid <= 1'b0;

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d pose pairs against %0d coefficient sets, %0d mismatches.",
                 requests_seen, results_seen, fail_count);
        $display("Covered full-scale headings, saturating offsets, a %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
